@@ src/llh_pkg.sv @@
// ----------------------------------------------------------------------------
// llh_pkg: shared definitions for the log2 latency histogram
// Field widths, command codes, default sizes and the percentile result record.
// ----------------------------------------------------------------------------
`default_nettype none

package llh_pkg;

	localparam int NUM_BUCKETS_DEF = 32;
	localparam int COUNT_WIDTH_DEF = 32;

	localparam int LAT_W     = 64;
	localparam int SEL_W     = 6;
	localparam int FRAC_W    = 17;
	localparam int FRAC_BITS = 16;
	localparam int OUT_CNT_W = 32;
	localparam int CNT_MAX_W = 64;
	localparam int PROD_W    = 2 * LAT_W;

	localparam int S_TDATA_W = 88;
	localparam int M_TDATA_W = 328;

	localparam logic [FRAC_W-1:0] FRAC_ONE = FRAC_W'(1) << FRAC_BITS;

	typedef enum logic [1:0] {
		FUNC_REC,
		FUNC_CLR,
		FUNC_RD,
		FUNC_PCT
	} func_t;

	typedef struct packed {
		logic                 busy;
		logic                 done;
		logic [LAT_W-1:0]     value;
		logic [SEL_W-1:0]     found;
		logic [CNT_MAX_W-1:0] hits;
	} pct_res_t;

endpackage

`default_nettype wire

@@ src/log2_latency_histogram_unit.sv @@
// ----------------------------------------------------------------------------
// log2_latency_histogram_unit: power-of-two latency histogram with percentiles
// Record, clear and bucket read requests follow one another back to back
// while the output is not stalled; the result passes the request stage and then
// the output register, the bucket memory giving registered read data.
// A percentile request holds the input while it runs: 17 multiply steps, a
// walk over the buckets and 128 divider steps.
// Reset clears the store at once through per-bucket valid flags.
// ----------------------------------------------------------------------------
`default_nettype none

module log2_latency_histogram_unit import llh_pkg::*; #(
	parameter int NUM_BUCKETS = NUM_BUCKETS_DEF,
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	// latency_ns[63:0], bucket_select[69:64], fraction_q16[86:70], zero pad
	input  wire logic [S_TDATA_W-1:0] s_tdata,
	// func[1:0]
	input  wire logic [1:0]           s_tuser,
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	// value[63:0], bucket_found[69:64], bucket_hits[101:70], total_count[133:102],
	// total_sum[197:134], min_latency[261:198], max_latency[325:262],
	// is_empty[326], zero pad
	output logic      [M_TDATA_W-1:0] m_tdata
);

	localparam int IW = $clog2(NUM_BUCKETS);
	localparam logic [IW-1:0]          LAST_IDX = IW'(NUM_BUCKETS - 1);
	localparam logic [COUNT_WIDTH-1:0] CNT_MAX  = '1;

	func_t             in_func;
	logic [LAT_W-1:0]  in_lat;
	logic [SEL_W-1:0]  in_sel;
	logic [FRAC_W-1:0] in_frac;
	logic [SEL_W:0]    in_hb;
	logic [IW-1:0]     in_bucket;
	logic              in_sel_ok;
	logic              accept;
	logic              top_re;
	logic [IW-1:0]     top_raddr;

	logic                   valid_s1;
	func_t                  func_s1;
	logic [LAT_W-1:0]       lat_s1;
	logic [IW-1:0]          bucket_s1;
	logic [SEL_W-1:0]       sel_s1;
	logic                   sel_ok_s1;
	logic [FRAC_W-1:0]      frac_s1;
	logic                   s1_done;
	logic                   s1_adv;

	logic [COUNT_WIDTH-1:0] count_q;
	logic [LAT_W-1:0]       sum_q;
	logic [LAT_W-1:0]       min_q;
	logic [LAT_W-1:0]       max_q;

	logic [COUNT_WIDTH-1:0] cnt_after;
	logic [LAT_W-1:0]       sum_after;
	logic [LAT_W-1:0]       min_after;
	logic [LAT_W-1:0]       max_after;

	logic                   ram_re;
	logic [IW-1:0]          ram_raddr;
	logic [COUNT_WIDTH-1:0] ram_rdata;
	logic                   ram_we;
	logic                   ram_clr;
	logic [COUNT_WIDTH-1:0] rec_hits;

	logic                   pct_start;
	logic                   pct_rd_en;
	logic [IW-1:0]          pct_rd_addr;
	pct_res_t               pct_res;

	logic [LAT_W-1:0]       res_value;
	logic [SEL_W-1:0]       res_found;
	logic [COUNT_WIDTH-1:0] res_hits;
	logic                   res_empty;
	logic [M_TDATA_W-1:0]   res_word;

	logic                   m_valid_q;
	logic [M_TDATA_W-1:0]   m_data_q;

	// Input side and bucket index
	always_comb begin
		in_func = func_t'(s_tuser);
		in_lat  = s_tdata[LAT_W-1:0];
		in_sel  = s_tdata[LAT_W +: SEL_W];
		in_frac = s_tdata[LAT_W+SEL_W +: FRAC_W];

		// in_hb ends as floor(log2) + 1 of the latency, or zero for a zero latency.
		in_hb = '0;
		for (int i = 0; i < LAT_W; i++) begin
			if (in_lat[i]) begin
				in_hb = (SEL_W + 1)'(i + 1);
			end
		end
		in_bucket = (int'(in_hb) > NUM_BUCKETS - 1) ? LAST_IDX : IW'(in_hb);
		in_sel_ok = {1'b0, in_sel} < (SEL_W + 1)'(NUM_BUCKETS);
	end

	assign s1_done  = (func_s1 != FUNC_PCT) || (count_q == '0) || pct_res.done;
	assign s1_adv   = valid_s1 && s1_done && (!m_valid_q || m_tready);
	assign s_tready = !valid_s1 || s1_adv;
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		top_re    = accept && (in_func inside {FUNC_REC, FUNC_RD});
		top_raddr = '0;
		if (in_func == FUNC_REC) begin
			top_raddr = in_bucket;
		end else if (in_sel_ok) begin
			top_raddr = in_sel[IW-1:0];
		end
		ram_re    = top_re || pct_rd_en;
		ram_raddr = pct_rd_en ? pct_rd_addr : top_raddr;
	end

	// Bucket store and percentile engine
	assign rec_hits = (ram_rdata == CNT_MAX) ? ram_rdata : ram_rdata + 1'b1;
	assign ram_we   = s1_adv && (func_s1 == FUNC_REC);
	assign ram_clr  = s1_adv && (func_s1 == FUNC_CLR);

	llh_bucket_ram #(
		.NUM_BUCKETS (NUM_BUCKETS),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_ram (
		.clk    (clk),
		.arst_n (arst_n),
		.clr    (ram_clr),
		.we     (ram_we),
		.waddr  (bucket_s1),
		.wdata  (rec_hits),
		.re     (ram_re),
		.raddr  (ram_raddr),
		.rdata  (ram_rdata)
	);

	assign pct_start = valid_s1 && (func_s1 == FUNC_PCT) && (count_q != '0);

	llh_pct_unit #(
		.NUM_BUCKETS (NUM_BUCKETS),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_pct (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (pct_start),
		.ack      (s1_adv),
		.count    (count_q),
		.fraction (frac_s1),
		.rd_en    (pct_rd_en),
		.rd_addr  (pct_rd_addr),
		.rd_data  (ram_rdata),
		.res      (pct_res)
	);

	// Request stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1   <= in_func;
			lat_s1    <= in_lat;
			bucket_s1 <= in_bucket;
			sel_s1    <= in_sel;
			sel_ok_s1 <= in_sel_ok;
			frac_s1   <= in_frac;
		end
	end

	// Statistics as they stand after the request in the stage
	always_comb begin
		cnt_after = count_q;
		sum_after = sum_q;
		min_after = min_q;
		max_after = max_q;
		case (func_s1)
			FUNC_REC: begin
				cnt_after = (count_q == CNT_MAX) ? count_q : count_q + 1'b1;
				sum_after = sum_q + lat_s1;
				min_after = (lat_s1 < min_q) ? lat_s1 : min_q;
				max_after = (lat_s1 > max_q) ? lat_s1 : max_q;
			end
			FUNC_CLR: begin
				cnt_after = '0;
				sum_after = '0;
				min_after = '1;
				max_after = '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sum_q   <= '0;
			min_q   <= '1;
			max_q   <= '0;
		end else if (s1_adv) begin
			count_q <= cnt_after;
			sum_q   <= sum_after;
			min_q   <= min_after;
			max_q   <= max_after;
		end
	end

	// Result assembly
	always_comb begin
		res_value = '0;
		res_found = '0;
		res_hits  = '0;
		case (func_s1)
			FUNC_REC: begin
				res_found = SEL_W'(bucket_s1);
				res_hits  = rec_hits;
			end
			FUNC_RD: begin
				res_found = sel_s1;
				res_hits  = sel_ok_s1 ? ram_rdata : '0;
			end
			FUNC_PCT: begin
				if (count_q != '0) begin
					res_value = pct_res.value;
					res_found = pct_res.found;
					res_hits  = pct_res.hits[COUNT_WIDTH-1:0];
				end
			end
			default: begin
			end
		endcase
		res_empty = (cnt_after == '0);
		res_word  = {
			{(M_TDATA_W - 327){1'b0}},
			res_empty,
			res_empty ? {LAT_W{1'b0}} : max_after,
			res_empty ? {LAT_W{1'b0}} : min_after,
			sum_after,
			OUT_CNT_W'(cnt_after),
			OUT_CNT_W'(res_hits),
			res_found,
			res_value
		};
	end

	// Output register: a finished result waits here while the next request runs.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (s1_adv) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			m_data_q <= res_word;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	// Checks
	a_query_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		pct_res.busy |-> !s_tready)
		else $error("input accepted while a percentile query is running");

	a_clear_resets_stats: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_adv && (func_s1 == FUNC_CLR)) |=> ((count_q == '0) && (sum_q == '0)
		&& (max_q == '0) && (min_q == '1)))
		else $error("statistics not back at reset values after a clear");

	a_record_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_adv && (func_s1 == FUNC_REC)) |=> (count_q != '0))
		else $error("count still zero after a record");

	a_found_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		pct_res.done |-> (pct_res.found <= SEL_W'(NUM_BUCKETS - 1)))
		else $error("percentile bucket beyond the last bucket");

endmodule

`default_nettype wire

@@ src/llh_bucket_ram.sv @@
// ----------------------------------------------------------------------------
// llh_bucket_ram: bucket count store
// One write port and one read port with registered read data. Per-entry valid
// flags make a cleared entry read as zero; writes are forwarded to a read of
// the same entry in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module llh_bucket_ram import llh_pkg::*; #(
	parameter int NUM_BUCKETS = NUM_BUCKETS_DEF,
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           clr,
	input  wire logic                           we,
	input  wire logic [$clog2(NUM_BUCKETS)-1:0] waddr,
	input  wire logic [COUNT_WIDTH-1:0]         wdata,
	input  wire logic                           re,
	input  wire logic [$clog2(NUM_BUCKETS)-1:0] raddr,
	output logic      [COUNT_WIDTH-1:0]         rdata
);

	logic [COUNT_WIDTH-1:0] mem [NUM_BUCKETS];
	logic [NUM_BUCKETS-1:0] valid_q;
	logic [COUNT_WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (clr) begin
			valid_q <= '0;
		end else if (we) begin
			valid_q[waddr] <= 1'b1;
		end
	end

	// The read data holds while no read is requested.
	always_ff @(posedge clk) begin
		if (re) begin
			if (clr) begin
				rdata_q <= '0;
			end else if (we && (waddr == raddr)) begin
				rdata_q <= wdata;
			end else if (valid_q[raddr]) begin
				rdata_q <= mem[raddr];
			end else begin
				rdata_q <= '0;
			end
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

@@ src/llh_div_unit.sv @@
// ----------------------------------------------------------------------------
// llh_div_unit: restoring divider
// Produces one quotient bit per cycle; done pulses for one cycle once the
// last quotient bit has been shifted in.
// ----------------------------------------------------------------------------
`default_nettype none

module llh_div_unit import llh_pkg::*; #(
	parameter int NUM_W = PROD_W,
	parameter int DEN_W = COUNT_WIDTH_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [NUM_W-1:0] num,
	input  wire logic [DEN_W-1:0] den,
	output logic                  done,
	output logic      [NUM_W-1:0] quot
);

	localparam int CNT_W = $clog2(NUM_W);

	logic             run_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [NUM_W-1:0] nq_q;

	logic [DEN_W:0] rem_sh;
	logic [DEN_W:0] diff;
	logic           ge;

	always_comb begin
		rem_sh = {rem_q, nq_q[NUM_W-1]};
		diff   = rem_sh - {1'b0, den_q};
		ge     = rem_sh >= {1'b0, den_q};
	end

	// Dividend bits leave at the top of nq_q while quotient bits enter at the bottom.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			den_q  <= '0;
			nq_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(NUM_W - 1);
				rem_q <= '0;
				den_q <= den;
				nq_q  <= num;
			end else if (run_q) begin
				rem_q <= ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
				nq_q  <= {nq_q[NUM_W-2:0], ge};
				if (cnt_q == '0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quot = nq_q;

endmodule

`default_nettype wire

@@ src/llh_pct_unit.sv @@
// ----------------------------------------------------------------------------
// llh_pct_unit: percentile query engine
// Forms the target rank by shift-and-add, walks the bucket store one entry a
// cycle, then interpolates inside the bucket with its own divider.
// ----------------------------------------------------------------------------
`default_nettype none

module llh_pct_unit import llh_pkg::*; #(
	parameter int NUM_BUCKETS = NUM_BUCKETS_DEF,
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	input  wire logic                           ack,
	input  wire logic [COUNT_WIDTH-1:0]         count,
	input  wire logic [FRAC_W-1:0]              fraction,
	output logic                                rd_en,
	output logic      [$clog2(NUM_BUCKETS)-1:0] rd_addr,
	input  wire logic [COUNT_WIDTH-1:0]         rd_data,
	output pct_res_t                            res
);

	localparam int IW     = $clog2(NUM_BUCKETS);
	localparam int PW     = COUNT_WIDTH + FRAC_W;
	localparam int STEP_W = $clog2(FRAC_W);
	localparam logic [IW-1:0] LAST_IDX = IW'(NUM_BUCKETS - 1);
	localparam logic [PW:0]   ROUND_UP = (PW + 1)'((1 << FRAC_BITS) - 1);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL,
		ST_TGT,
		ST_WALK,
		ST_TIB,
		ST_PRODA,
		ST_PRODB,
		ST_DIV,
		ST_DONE
	} state_t;

	state_t                 state_q;
	logic [COUNT_WIDTH-1:0] cnt_q;
	logic [FRAC_W-1:0]      frac_q;
	logic [PW-1:0]          acc_q;
	logic [STEP_W-1:0]      step_q;
	logic [COUNT_WIDTH-1:0] target_q;
	logic [LAT_W-1:0]       cum_q;
	logic [LAT_W-1:0]       prev_q;
	logic [IW-1:0]          idx_q;
	logic [IW-1:0]          found_q;
	logic [COUNT_WIDTH-1:0] bc_q;
	logic [COUNT_WIDTH-1:0] tib_q;
	logic [PROD_W-1:0]      base_q;
	logic [PROD_W-1:0]      shf_q;
	logic [LAT_W-1:0]       value_q;
	logic [COUNT_WIDTH-1:0] hits_q;

	logic [LAT_W:0]         cum_sum;
	logic [LAT_W-1:0]       cum_n;
	logic                   walk_hit;
	logic [PW:0]            rnd;
	logic [LAT_W-1:0]       gap;
	logic                   div_start;
	logic [PROD_W-1:0]      div_num;
	logic                   div_done;
	logic [PROD_W-1:0]      div_quot;

	function automatic logic [LAT_W-1:0] lower_of(input logic [IW-1:0] idx);
		logic [LAT_W-1:0] r;
		r = '0;
		if (idx != '0) begin
			r = LAT_W'(1) << (int'(idx) - 1);
		end
		return r;
	endfunction

	// Midpoint of a bucket, truncated; the open-ended last bucket uses its lower bound.
	function automatic logic [LAT_W-1:0] mid_of(input logic [IW-1:0] idx);
		logic [LAT_W-1:0] r;
		r = lower_of(idx);
		if ((idx != LAST_IDX) && (int'(idx) >= 2)) begin
			r = r | (LAT_W'(1) << (int'(idx) - 2));
		end
		return r;
	endfunction

	// Bucket width is a power of two, except for the last bucket.
	function automatic int width_shift(input logic [IW-1:0] idx);
		return (idx == '0) ? 0 : int'(idx) - 1;
	endfunction

	always_comb begin
		cum_sum  = {1'b0, cum_q} + (LAT_W + 1)'(rd_data);
		cum_n    = cum_sum[LAT_W] ? '1 : cum_sum[LAT_W-1:0];
		walk_hit = cum_n >= LAT_W'(target_q);
		rnd      = {1'b0, acc_q} + ROUND_UP;
		gap      = LAT_W'(target_q) - prev_q;
	end

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		case (state_q)
			ST_TGT: begin
				rd_en = 1'b1;
			end
			ST_WALK: begin
				if (!walk_hit && (idx_q != LAST_IDX)) begin
					rd_en   = 1'b1;
					rd_addr = idx_q + 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign div_start = (state_q == ST_PRODB);
	assign div_num   = (found_q == LAST_IDX) ? (base_q - shf_q) : shf_q;

	llh_div_unit #(
		.NUM_W (PROD_W),
		.DEN_W (COUNT_WIDTH)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (bc_q),
		.done   (div_done),
		.quot   (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			frac_q   <= '0;
			acc_q    <= '0;
			step_q   <= '0;
			target_q <= '0;
			cum_q    <= '0;
			prev_q   <= '0;
			idx_q    <= '0;
			found_q  <= '0;
			bc_q     <= '0;
			tib_q    <= '0;
			base_q   <= '0;
			shf_q    <= '0;
			value_q  <= '0;
			hits_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						cnt_q   <= count;
						frac_q  <= (fraction > FRAC_ONE) ? FRAC_ONE : fraction;
						acc_q   <= '0;
						step_q  <= STEP_W'(FRAC_W - 1);
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					acc_q  <= (acc_q << 1) + PW'(frac_q[FRAC_W-1] ? cnt_q : '0);
					frac_q <= frac_q << 1;
					step_q <= step_q - 1'b1;
					if (step_q == '0) begin
						state_q <= ST_TGT;
					end
				end
				ST_TGT: begin
					// Rounding up before the shift gives the ceiling of the rank.
					target_q <= rnd[COUNT_WIDTH+FRAC_BITS-1:FRAC_BITS];
					cum_q    <= '0;
					idx_q    <= '0;
					state_q  <= ST_WALK;
				end
				ST_WALK: begin
					if (walk_hit) begin
						prev_q  <= cum_q;
						bc_q    <= rd_data;
						found_q <= idx_q;
						hits_q  <= rd_data;
						if (rd_data == '0) begin
							value_q <= mid_of(idx_q);
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_TIB;
						end
					end else if (idx_q == LAST_IDX) begin
						value_q <= '1;
						found_q <= LAST_IDX;
						hits_q  <= rd_data;
						state_q <= ST_DONE;
					end else begin
						idx_q <= idx_q + 1'b1;
						cum_q <= cum_n;
					end
				end
				ST_TIB: begin
					tib_q   <= (gap > LAT_W'(bc_q)) ? bc_q : COUNT_WIDTH'(gap);
					state_q <= ST_PRODA;
				end
				ST_PRODA: begin
					// The last bucket spans 2^64 - 1 - lower; the rest span a power of two.
					shf_q   <= PROD_W'(tib_q) << width_shift(found_q);
					base_q  <= (PROD_W'(tib_q) << LAT_W) - PROD_W'(tib_q);
					state_q <= ST_PRODB;
				end
				ST_PRODB: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_done) begin
						value_q <= lower_of(found_q) + div_quot[LAT_W-1:0];
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (ack) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		res.busy  = (state_q != ST_IDLE) && (state_q != ST_DONE);
		res.done  = (state_q == ST_DONE);
		res.value = value_q;
		res.found = SEL_W'(found_q);
		res.hits  = CNT_MAX_W'(hits_q);
	end

endmodule

`default_nettype wire
